// ----- rtl/slp24_pkg.sv -----
`timescale 1ns / 1ps

package slp24_pkg;

    localparam int LONG_LAG  = 24;
    localparam int SHORT_LAG = 10;
    localparam int WORD_W    = 24;
    localparam int SLOT_W    = $clog2(LONG_LAG);
    localparam int SKIP_W    = 9;
    localparam int OUT_W     = 32;
    localparam int SEED_W    = 32;
    localparam int LUX_W     = 3;
    localparam int LAG_GAP   = LONG_LAG - SHORT_LAG;

    localparam logic [SLOT_W-1:0] LONG_SLOT0  = SLOT_W'(LONG_LAG - 1);
    localparam logic [SLOT_W-1:0] SHORT_SLOT0 = SLOT_W'(SHORT_LAG - 1);
    localparam logic [LUX_W-1:0]  LUX_RESET   = LUX_W'(1);

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // one read pair issued to the lag memory
    typedef struct packed {
        logic              issue;
        logic [SLOT_W-1:0] long_slot;
        logic [SLOT_W-1:0] short_slot;
        logic              keep;
        logic              first;
    } issue_t;

    // seed write into the lag memory
    typedef struct packed {
        logic              wr;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] data;
    } seed_t;

    // step a lag slot down, wrapping the lowest slot to the top
    function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
        if (s == '0) begin
            prev_slot = LONG_SLOT0;
        end else begin
            prev_slot = s - 1'b1;
        end
    endfunction

    // words discarded per block for each luxury level
    function automatic logic [SKIP_W-1:0] skip_count(input logic [LUX_W-1:0] level);
        case (level)
            3'd0:    skip_count = SKIP_W'(0);
            3'd1:    skip_count = SKIP_W'(24);
            3'd2:    skip_count = SKIP_W'(73);
            3'd3:    skip_count = SKIP_W'(199);
            3'd4:    skip_count = SKIP_W'(365);
            default: skip_count = SKIP_W'(0);
        endcase
    endfunction

endpackage

// ----- rtl/slp24_ram.sv -----
`timescale 1ns / 1ps

module slp24_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ----- rtl/slp24_datapath.sv -----
`timescale 1ns / 1ps

module slp24_datapath
    import slp24_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  issue_t           iss,
    input  seed_t            seed,
    output logic [OUT_W-1:0] res_value
);

    logic [WORD_W-1:0] rd_long, rd_short;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;

    logic              st_valid_reg;
    logic              st_keep_reg, st_first_reg;
    logic [SLOT_W-1:0] st_long_reg;
    logic              vl_reg, vs_reg;
    logic              fwd_l_reg, fwd_s_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              borrow_reg;
    logic [LONG_LAG-1:0] valid_reg;
    logic [7:0]        hi_reg;
    logic [OUT_W-1:0]  value_reg;

    logic [WORD_W-1:0] xl, xs;
    logic [WORD_W:0]   diff;

    slp24_ram #(
        .WIDTH (WORD_W),
        .DEPTH (LONG_LAG)
    ) u_lag_ram (
        .clk     (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (iss.long_slot),
        .rdata_a (rd_long),
        .raddr_b (iss.short_slot),
        .rdata_b (rd_short)
    );

    // forwarded write, then never-written slots read as zero
    always_comb begin
        xl   = fwd_l_reg ? fwd_data_reg : (vl_reg ? rd_long : '0);
        xs   = fwd_s_reg ? fwd_data_reg : (vs_reg ? rd_short : '0);
        diff = {1'b0, xs} - {1'b0, xl} - {{WORD_W{1'b0}}, borrow_reg};
    end

    assign we    = seed.wr | st_valid_reg;
    assign waddr = seed.wr ? seed.slot : st_long_reg;
    assign wdata = seed.wr ? seed.data : diff[WORD_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            borrow_reg   <= 1'b1;
            valid_reg    <= '0;
        end else begin
            st_valid_reg <= iss.issue;
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            if (seed.wr) begin
                borrow_reg <= 1'b1;
            end else if (st_valid_reg) begin
                borrow_reg <= diff[WORD_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        st_keep_reg  <= iss.keep;
        st_first_reg <= iss.first;
        st_long_reg  <= iss.long_slot;
        vl_reg       <= valid_reg[iss.long_slot];
        vs_reg       <= valid_reg[iss.short_slot];
        fwd_l_reg    <= we && (waddr == iss.long_slot);
        fwd_s_reg    <= we && (waddr == iss.short_slot);
        fwd_data_reg <= wdata;
        if (st_valid_reg && st_keep_reg && st_first_reg) begin
            hi_reg <= diff[WORD_W-1:WORD_W-8];
        end
        if (st_valid_reg && st_keep_reg && !st_first_reg) begin
            value_reg <= {diff[WORD_W-1:0], hi_reg};
        end
    end

    assign res_value = value_reg;

    // the single write port never sees a seed and a generated word together
    a_no_write_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg |-> !seed.wr)
        else $error("seed write collides with generated word");

    // a written slot is readable afterwards
    a_valid_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        we |=> valid_reg[$past(waddr)])
        else $error("valid bit not set after write");

endmodule

// ----- rtl/slp24_seq.sv -----
`timescale 1ns / 1ps

module slp24_seq
    import slp24_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [LUX_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_kind,
    input  logic [SEED_W-1:0] in_seed,
    input  logic              out_free,
    output logic              out_load,
    output issue_t            iss,
    output seed_t             seed
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_BUMP = 5'b00010,
        S_RUN  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] long_slot_reg, long_slot_next;
    logic [SLOT_W-1:0] short_slot_reg, short_slot_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [SLOT_W-1:0] seed_ptr_reg, seed_ptr_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic              first_reg, first_next;
    logic [LUX_W-1:0]  lux_reg;
    logic [SLOT_W:0]   pos_inc;
    logic [WORD_W-1:0] seed_word;
    logic              gap_ok;

    always_comb begin
        state_next      = state_reg;
        long_slot_next  = long_slot_reg;
        short_slot_next = short_slot_reg;
        pos_next        = pos_reg;
        seed_ptr_next   = seed_ptr_reg;
        skip_next       = skip_reg;
        first_next      = first_reg;
        in_ready        = 1'b0;
        out_load        = 1'b0;
        pos_inc         = {1'b0, pos_reg} + 1'b1;

        seed_word = in_seed[WORD_W-1:0];
        if (seed_ptr_reg == SLOT_W'(0)) begin
            seed_word[0] = 1'b1;
        end
        if (seed_ptr_reg == SLOT_W'(1)) begin
            seed_word[0] = 1'b0;
        end
        seed.wr   = 1'b0;
        seed.slot = seed_ptr_reg;
        seed.data = seed_word;

        iss.issue      = 1'b0;
        iss.long_slot  = long_slot_reg;
        iss.short_slot = short_slot_reg;
        iss.keep       = (skip_reg == '0);
        iss.first      = first_reg;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_kind == KIND_SEED) begin
                        seed.wr         = 1'b1;
                        seed_ptr_next   = (seed_ptr_reg == LONG_SLOT0) ? '0
                                                                       : seed_ptr_reg + 1'b1;
                        long_slot_next  = LONG_SLOT0;
                        short_slot_next = SHORT_SLOT0;
                        pos_next        = '0;
                    end else begin
                        first_next = 1'b1;
                        state_next = S_BUMP;
                    end
                end
            end
            S_BUMP: begin
                // advance the block counter; at a block end load the discard run
                if (pos_inc >= (SLOT_W+1)'(LONG_LAG)) begin
                    pos_next  = '0;
                    skip_next = skip_count(lux_reg);
                end else begin
                    pos_next  = pos_inc[SLOT_W-1:0];
                    skip_next = '0;
                end
                state_next = S_RUN;
            end
            S_RUN: begin
                iss.issue       = 1'b1;
                long_slot_next  = prev_slot(long_slot_reg);
                short_slot_next = prev_slot(short_slot_reg);
                if (skip_reg != '0) begin
                    skip_next = skip_reg - 1'b1;
                end else if (first_reg) begin
                    first_next = 1'b0;
                    state_next = S_BUMP;
                end else begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            long_slot_reg  <= LONG_SLOT0;
            short_slot_reg <= SHORT_SLOT0;
            pos_reg        <= '0;
            seed_ptr_reg   <= '0;
            skip_reg       <= '0;
            first_reg      <= 1'b0;
            lux_reg        <= LUX_RESET;
        end else begin
            state_reg      <= state_next;
            long_slot_reg  <= long_slot_next;
            short_slot_reg <= short_slot_next;
            pos_reg        <= pos_next;
            seed_ptr_reg   <= seed_ptr_next;
            skip_reg       <= skip_next;
            first_reg      <= first_next;
            if (cfg_we) begin
                lux_reg <= cfg_wdata;
            end
        end
    end

    // the short tap always trails the long tap by the lag gap
    assign gap_ok = ({1'b0, long_slot_reg} >= (SLOT_W+1)'(LAG_GAP)) ?
                    ({1'b0, short_slot_reg} == {1'b0, long_slot_reg} - (SLOT_W+1)'(LAG_GAP)) :
                    ({1'b0, short_slot_reg} == {1'b0, long_slot_reg} + (SLOT_W+1)'(SHORT_LAG));

    a_lag_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        gap_ok)
        else $error("lag taps out of step");

    a_draw_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && in_valid && in_kind == KIND_DRAW) |=> state_reg == S_BUMP)
        else $error("draw did not start a block step");

    a_wait_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WAIT) |=> (state_reg == S_OUT))
        else $error("last word did not move to output");

    a_seed_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        seed_ptr_reg <= LONG_SLOT0 && pos_reg <= LONG_SLOT0)
        else $error("seed pointer or block position out of range");

endmodule

// ----- rtl/swb_luxury_prng_24_top.sv -----
`timescale 1ns / 1ps

// Timing: a seed item is written to the lag memory as it is taken. A draw item
//   goes S_BUMP, S_RUN for each word (S_RUN also issues the d words discarded
//   at block ends), then S_WAIT, S_OUT. Throughput: one lag word per cycle
//   through the lag memory read/modify/write loop while S_RUN issues.
// Reset (aresetn low, synchronous): lag words read as zero, borrow 1, taps back
//   to their start slots, block counter and seed pointer 0, luxury level 1.
module swb_luxury_prng_24_top
    import slp24_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // luxury level register, written whenever cfg_we is high
    input  logic              cfg_we,
    input  logic [LUX_W-1:0]  cfg_wdata,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [SEED_W-1:0] s_tdata,   // [31:0] seed_word
    input  logic [0:0]        s_tuser,   // [0] kind: 0 = seed, 1 = draw
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata    // [31:0] random_value
);

    issue_t           iss;
    seed_t            seed;
    logic             out_free;
    logic             out_load;
    logic [OUT_W-1:0] res_value;
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    // The output register frees the sequencer: a result may wait here while
    // the next item is already taken and worked on.
    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer: handshake, tap slots, block counter and discard runs.
    slp24_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[0]),
        .in_seed   (s_tdata),
        .out_free  (out_free),
        .out_load  (out_load),
        .iss       (iss),
        .seed      (seed)
    );

    // Datapath: lag memory, subtract with borrow, write-back forwarding.
    slp24_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iss       (iss),
        .seed      (seed),
        .res_value (res_value)
    );

    // Hold the result until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= res_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a new result is loaded only into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwritten before it was taken");

endmodule

// ----- bench/tb_swb_luxury_prng_24_top.sv -----
`timescale 1ns / 1ps

module tb_swb_luxury_prng_24_top;
    import slp24_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int NUM_PHASES    = 16;
    localparam int QUIET_PHASES  = 2;      // final phases run without any idling
    localparam int SETTLE_CYCLES = 400;    // covers a draw that ends a block at level 4
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic              kind;
        logic [SEED_W-1:0] seed_word;
    } prng_item_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [LUX_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [SEED_W-1:0] s_tdata   = '0;   // [31:0] seed_word
    logic [0:0]        s_tuser   = '0;   // [0] kind
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;          // [31:0] random_value

    swb_luxury_prng_24_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    // ------------------------------------------------------------------
    // Generator state mirrored in the bench
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] lag_mem [LONG_LAG];
    logic              carry_bit;
    int unsigned       tap_long;           // 1..LONG_LAG, slot is tap - 1
    int unsigned       tap_short;
    int unsigned       block_count;
    int unsigned       seed_slot;
    logic [LUX_W-1:0]  lux_level_model;

    int unsigned discard_per_block [5] = '{0, 24, 73, 199, 365};

    prng_item_t       pending_items [$];
    logic [OUT_W-1:0] expected_values [$];

    prng_item_t offered_item;
    bit         offer_live  = 1'b0;
    bit         quiet_run   = 1'b0;
    bit         hold_req    = 1'b0;
    int         gap_left    = 0;
    int         stall_left  = 0;
    int         hold_left   = 0;

    int error_count     = 0;
    int report_count    = 0;
    int results_checked = 0;
    int seeds_loaded    = 0;
    int draws_sent      = 0;
    int phases_run      = 0;
    int cycle_count     = 0;

    // one subtract-with-borrow step; the new word replaces the long-lag slot
    function automatic logic [WORD_W-1:0] swb_word();
        logic [WORD_W:0] diff;
        diff = {1'b0, lag_mem[tap_short-1]} - {1'b0, lag_mem[tap_long-1]}
             - {{WORD_W{1'b0}}, carry_bit};
        carry_bit = diff[WORD_W];
        lag_mem[tap_long-1] = diff[WORD_W-1:0];
        tap_long  = (tap_long  <= 1) ? LONG_LAG : tap_long  - 1;
        tap_short = (tap_short <= 1) ? LONG_LAG : tap_short - 1;
        return diff[WORD_W-1:0];
    endfunction

    // advance the block counter and throw away the luxury words at block end
    function automatic logic [WORD_W-1:0] luxury_word();
        int unsigned discard;
        block_count++;
        if (block_count >= LONG_LAG) begin
            discard     = (lux_level_model <= 4) ? discard_per_block[lux_level_model] : 0;
            block_count = 0;
            repeat (discard) void'(swb_word());
        end
        return swb_word();
    endfunction

    function automatic logic [OUT_W-1:0] draw_value();
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        first_word  = luxury_word();
        second_word = luxury_word();
        return {second_word, first_word[WORD_W-1:WORD_W-8]};
    endfunction

    function automatic void load_seed_word(input logic [SEED_W-1:0] raw);
        logic [WORD_W-1:0] w;
        w = raw[WORD_W-1:0];
        if (seed_slot == 0) w[0] = 1'b1;
        if (seed_slot == 1) w[0] = 1'b0;
        lag_mem[seed_slot] = w;
        seed_slot   = (seed_slot >= LONG_LAG - 1) ? 0 : seed_slot + 1;
        carry_bit   = 1'b1;
        tap_long    = LONG_LAG;
        tap_short   = SHORT_LAG;
        block_count = 0;
    endfunction

    function automatic void clear_generator();
        foreach (lag_mem[k]) lag_mem[k] = '0;
        carry_bit       = 1'b1;
        tap_long        = LONG_LAG;
        tap_short       = SHORT_LAG;
        block_count     = 0;
        seed_slot       = 0;
        lux_level_model = LUX_RESET;
    endfunction

    // bias seed content toward the edges of the word
    function automatic logic [SEED_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h00FF_FFFF;
            3:       return 32'hFF00_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_seed(input logic [SEED_W-1:0] w);
        pending_items.push_back('{kind: KIND_SEED, seed_word: w});
    endtask

    // the data field of a draw is ignored, so fill it with noise
    task automatic push_draw();
        pending_items.push_back('{kind: KIND_DRAW, seed_word: $urandom});
    endtask

    task automatic wait_for_results();
        while (pending_items.size() != 0 || offer_live || expected_values.size() != 0)
            @(posedge aclk);
    endtask

    // let a trailing seed or a discard run finish before touching the register
    task automatic settle_idle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_luxury(input logic [LUX_W-1:0] level);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= level;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        lux_level_model = level;
    endtask

    // ------------------------------------------------------------------
    // Driver: offer the next pending item on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (offer_live) begin
            s_tvalid <= 1'b1;               // hold the item until it is taken
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_tvalid <= 1'b0;
        end else if (!quiet_run && aresetn && $urandom_range(0, 4) == 0) begin
            gap_left <= $urandom_range(1, 8) - 1;
            s_tvalid <= 1'b0;
        end else if (aresetn && pending_items.size() != 0) begin
            offered_item = pending_items.pop_front();
            offer_live   = 1'b1;
            s_tdata  <= offered_item.seed_word;
            s_tuser  <= offered_item.kind;
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input acceptance, compare on output acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                error_count++;
                if (report_count < MAX_REPORTS)
                    $display("[%0t] unexpected result random_value=%08h", $time, m_tdata);
                report_count++;
            end else begin
                logic [OUT_W-1:0] want;
                want = expected_values.pop_front();
                results_checked++;
                if (m_tdata !== want) begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                        $display("[%0t] random_value mismatch: expected %08h, got %08h",
                                 $time, want, m_tdata);
                    report_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready && offer_live) begin
            offer_live = 1'b0;
            if (offered_item.kind == KIND_DRAW) begin
                expected_values.push_back(draw_value());
                draws_sent++;
            end else begin
                load_seed_word(offered_item.seed_word);
                seeds_loaded++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [LUX_W-1:0] lux_plan [7] = '{3'd0, 3'd4, 3'd7, 3'd2, 3'd3, 3'd5, 3'd6};

    initial begin
        logic [LUX_W-1:0] level;
        int               n_draws;
        int               n_seeds;
        int               pick;

        clear_generator();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: draw on the reset state, then a short seed run that hits the
        // forced low bits of the first two slots and the masked top byte, then
        // enough draws to cross the first block end at the reset luxury level.
        push_draw();
        push_draw();
        push_seed(32'h0000_0000);
        push_seed(32'hFFFF_FFFF);
        push_seed(32'hFF00_0000);
        push_seed(32'h00FF_FFFF);
        repeat (12) push_draw();
        settle_idle();

        // Random phases: mostly a full reseed followed by a long draw run,
        // sometimes a partial reseed or none, with stray seeds mixed in.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            level = (phase < 7) ? lux_plan[phase] : LUX_W'($urandom_range(0, 7));
            if (phase >= NUM_PHASES - QUIET_PHASES) quiet_run = 1'b1;
            write_luxury(level);
            phases_run++;

            pick = $urandom_range(0, 9);
            if (phase < 2 || pick < 7) n_seeds = LONG_LAG;
            else if (pick < 9)         n_seeds = $urandom_range(1, 6);
            else                       n_seeds = 0;
            repeat (n_seeds) push_seed(pick_seed());

            // Phase 0 at level 0: stall the receiver for a long stretch while
            // draws keep coming, so the block backs up and drops s_tready.
            if (phase == 0) hold_req = 1'b1;

            n_draws = (phase == 0) ? 150 : $urandom_range(80, 110);
            for (int i = 0; i < n_draws; i++) begin
                // Phase 1: stop offering halfway until every result is back.
                if (phase == 1 && i == n_draws / 2) wait_for_results();
                if ($urandom_range(0, 39) == 0) push_seed(pick_seed());
                push_draw();
            end
            settle_idle();
        end

        if (expected_values.size() != 0) begin
            error_count++;
            $display("%0d expected results never arrived", expected_values.size());
        end

        $display("Run covered %0d draws and %0d seed words over %0d luxury phases",
                 draws_sent, seeds_loaded, phases_run + 1);
        $display("Compared %0d results, %0d failures", results_checked, error_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/slp24_pkg.sv
rtl/slp24_ram.sv
rtl/slp24_datapath.sv
rtl/slp24_seq.sv
rtl/swb_luxury_prng_24_top.sv
bench/tb_swb_luxury_prng_24_top.sv
